[rtl/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// operation and status codes, sequencer states and the default result width
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    FN_ADD = 2'd0,
    FN_SUB = 2'd1,
    FN_MUL = 2'd2,
    FN_DIV = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DIV0 = 2'd1,
    STAT_OVF  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_COMB,
    ST_COMB2,
    ST_CHECK,
    ST_STRIP,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_DONE
  } state_t;

endpackage

[rtl/rational_arith_unit_core.sv]
// ----------------------------------------------------------------------------
// rational_arith_unit_core: fraction add, subtract, multiply, divide, reduced
// by binary gcd on one shared 64-bit add/subtract unit, which also runs two
// divisions one quotient bit a cycle; busy stays high meanwhile; divide by
// zero returns in the cycle after start
// sync active-low reset clears sequencer and strobe; receiver cannot stall
// ----------------------------------------------------------------------------
module rational_arith_unit_core #(
  parameter int WIDTH = rau_pkg::WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_func,
  input  logic signed [31:0]    in_a_num,
  input  logic [30:0]           in_a_den,
  input  logic signed [31:0]    in_b_num,
  input  logic [30:0]           in_b_den,
  output logic                  out_valid,
  output logic signed [31:0]    out_res_num,
  output logic [30:0]           out_res_den,
  output rau_pkg::status_t      out_status
);

  import rau_pkg::*;

  localparam logic [63:0] LIMIT     = (64'd1 << (WIDTH - 1)) - 64'd1;
  localparam int          DIV_STEPS = 63;
  localparam int          CW        = $clog2(DIV_STEPS);

  state_t         state_r, state_nxt;
  func_t          func_r, func_nxt;
  logic [31:0]    ma_r, ma_nxt, mb_r, mb_nxt;
  logic [30:0]    ad_r, ad_nxt, bd_r, bd_nxt;
  logic           sa_r, sa_nxt, sb_r, sb_nxt, neg_r, neg_nxt;
  logic [63:0]    n_r, n_nxt, d_r, d_nxt, t_r, t_nxt;
  logic [63:0]    u_r, u_nxt, v_r, v_nxt, rem_r, rem_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [31:0]    res_num_r, res_num_nxt;
  logic [30:0]    res_den_r, res_den_nxt;
  status_t        status_r, status_nxt;

  logic [31:0]    mul_a, mul_b;
  logic [63:0]    prod;
  logic [63:0]    alu_a, alu_b;
  logic           alu_add;
  logic [64:0]    alu_res;
  logic           borrow;
  logic           sbe;
  logic [63:0]    div_src, rem_shift;
  logic [31:0]    in_ma, in_mb;
  func_t          in_fn;

  assign in_fn     = func_t'(in_func);
  assign in_ma     = in_a_num[31] ? (~in_a_num + 32'd1) : in_a_num;
  assign in_mb     = in_b_num[31] ? (~in_b_num + 32'd1) : in_b_num;
  assign sbe       = sb_r ^ (func_r == FN_SUB);
  assign div_src   = (state_r == ST_DIVN) ? n_r : d_r;
  assign rem_shift = {rem_r[62:0], div_src[62]};

  // shared multiplier, result always lands in a register
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL0: begin
        mul_a = ma_r;
        mul_b = (func_r == FN_MUL) ? mb_r : {1'b0, bd_r};
      end
      ST_MUL1: begin
        case (func_r)
          FN_ADD, FN_SUB: begin
            mul_a = mb_r;
            mul_b = {1'b0, ad_r};
          end
          FN_MUL: begin
            mul_a = {1'b0, ad_r};
            mul_b = {1'b0, bd_r};
          end
          default: begin
            mul_a = {1'b0, ad_r};
            mul_b = mb_r;
          end
        endcase
      end
      ST_MUL2: begin
        mul_a = {1'b0, ad_r};
        mul_b = {1'b0, bd_r};
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // shared add / subtract unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_add = 1'b0;
    case (state_r)
      ST_COMB: begin
        alu_a   = n_r;
        alu_b   = t_r;
        alu_add = (sa_r == sbe);
      end
      ST_COMB2: begin
        alu_a = t_r;
        alu_b = n_r;
      end
      ST_GCD: begin
        alu_a = u_r;
        alu_b = v_r;
      end
      ST_DIVN, ST_DIVD: begin
        alu_a = rem_shift;
        alu_b = v_r;
      end
      default: ;
    endcase
    alu_res = alu_add ? ({1'b0, alu_a} + {1'b0, alu_b})
                      : ({1'b0, alu_a} - {1'b0, alu_b});
  end

  assign borrow = alu_res[64];

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    ad_nxt        = ad_r;
    bd_nxt        = bd_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    neg_nxt       = neg_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    t_nxt         = t_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    res_num_nxt   = res_num_r;
    res_den_nxt   = res_den_r;
    status_nxt    = status_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          func_nxt = in_fn;
          ma_nxt   = in_ma;
          mb_nxt   = in_mb;
          ad_nxt   = in_a_den;
          bd_nxt   = in_b_den;
          sa_nxt   = in_a_num[31];
          sb_nxt   = in_b_num[31];
          if (in_a_den == '0 || in_b_den == '0 || (in_fn == FN_DIV && in_b_num == '0)) begin
            out_valid_nxt = 1'b1;
            res_num_nxt   = in_a_num;
            res_den_nxt   = in_a_den;
            status_nxt    = STAT_DIV0;
          end else begin
            state_nxt = ST_MUL0;
          end
        end
      end
      ST_MUL0: begin
        n_nxt     = prod;
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        if (func_r == FN_ADD || func_r == FN_SUB) begin
          t_nxt     = prod;
          state_nxt = ST_MUL2;
        end else begin
          d_nxt     = prod;
          neg_nxt   = sa_r ^ sb_r;
          state_nxt = ST_CHECK;
        end
      end
      ST_MUL2: begin
        d_nxt     = prod;
        state_nxt = ST_COMB;
      end
      ST_COMB: begin
        if (alu_add || !borrow) begin
          n_nxt     = alu_res[63:0];
          neg_nxt   = sa_r;
          state_nxt = ST_CHECK;
        end else begin
          state_nxt = ST_COMB2;
        end
      end
      ST_COMB2: begin
        n_nxt     = alu_res[63:0];
        neg_nxt   = sbe;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (n_r == '0) begin
          out_valid_nxt = 1'b1;
          res_num_nxt   = '0;
          res_den_nxt   = 31'd1;
          status_nxt    = STAT_OK;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_STRIP;
        end
      end
      ST_STRIP: begin
        // common factors of two come straight off both terms
        if (!n_r[0] && !d_r[0]) begin
          n_nxt = n_r >> 1;
          d_nxt = d_r >> 1;
        end else begin
          u_nxt     = n_r;
          v_nxt     = d_r;
          state_nxt = ST_GCD;
        end
      end
      ST_GCD: begin
        if (u_r == '0) begin
          // gcd is left in v
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIVN;
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (!borrow) begin
          u_nxt = alu_res[63:0];
        end else begin
          u_nxt = v_r;
          v_nxt = u_r;
        end
      end
      ST_DIVN, ST_DIVD: begin
        rem_nxt = borrow ? rem_shift : alu_res[63:0];
        if (state_r == ST_DIVN) begin
          n_nxt = {1'b0, n_r[61:0], ~borrow};
        end else begin
          d_nxt = {1'b0, d_r[61:0], ~borrow};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_STEPS - 1)) begin
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = (state_r == ST_DIVN) ? ST_DIVD : ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        if (n_r > LIMIT || d_r > LIMIT) begin
          res_num_nxt = '0;
          res_den_nxt = 31'd1;
          status_nxt  = STAT_OVF;
        end else begin
          res_num_nxt = neg_r ? (~n_r[31:0] + 32'd1) : n_r[31:0];
          res_den_nxt = d_r[30:0];
          status_nxt  = STAT_OK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r    <= func_nxt;
    ma_r      <= ma_nxt;
    mb_r      <= mb_nxt;
    ad_r      <= ad_nxt;
    bd_r      <= bd_nxt;
    sa_r      <= sa_nxt;
    sb_r      <= sb_nxt;
    neg_r     <= neg_nxt;
    n_r       <= n_nxt;
    d_r       <= d_nxt;
    t_r       <= t_nxt;
    u_r       <= u_nxt;
    v_r       <= v_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    res_num_r <= res_num_nxt;
    res_den_r <= res_den_nxt;
    status_r  <= status_nxt;
  end

  assign busy        = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_res_num = res_num_r;
  assign out_res_den = res_den_r;
  assign out_status  = status_r;

`ifndef SYNTHESIS
  a_den_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_DIV0 |-> out_res_den != '0)
    else $error("result word with zero denominator");

  a_ovf_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_OVF |-> out_res_num == '0 && out_res_den == 31'd1)
    else $error("overflow word not 0/1");

  a_div0_fast: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_a_den == '0 || in_b_den == '0)
    |=> out_valid && out_status == STAT_DIV0)
    else $error("zero denominator not flagged next cycle");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_GCD |-> v_r != '0)
    else $error("gcd operand went to zero");

  a_zero_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_OK && out_res_num == '0 |-> out_res_den == 31'd1)
    else $error("zero result not given as 0/1");
`endif

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the rational arithmetic core
// drives fraction words through the start/busy handshake, with random idle
// bursts, and checks every strobed result against an exact 64-bit predictor
// of the reduced fraction; a directed table of corner cases runs first, then
// a long mix of random small, factored, full-range, edge and divide-by-zero operands
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  import rau_pkg::*;

  localparam logic [63:0] RES_LIMIT = (64'd1 << (WIDTH_DEF - 1)) - 64'd1;
  localparam int          NUM_RANDOM = 1125;
  localparam int          CALM_TAIL  = 150;
  localparam int          DRAIN_CYCLES = 700;

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    status_t            status;
  } frac_t;

  typedef struct packed {
    func_t       op;
    logic [31:0] an;
    logic [30:0] ad;
    logic [31:0] bn;
    logic [30:0] bd;
    bit          known;
    frac_t       want;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_func;
  logic signed [31:0] in_a_num;
  logic [30:0]        in_a_den;
  logic signed [31:0] in_b_num;
  logic [30:0]        in_b_den;
  logic               out_valid;
  logic signed [31:0] out_res_num;
  logic [30:0]        out_res_den;
  status_t            out_status;

  frac_t     expected_fractions[$];
  stim_row_t directed_rows[$];
  int        mismatch_count;
  bit        idle_on;

  rational_arith_unit_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_func    (in_func),
    .in_a_num   (in_a_num),
    .in_a_den   (in_a_den),
    .in_b_num   (in_b_num),
    .in_b_den   (in_b_den),
    .out_valid  (out_valid),
    .out_res_num(out_res_num),
    .out_res_den(out_res_den),
    .out_status (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("** rational_arith_unit_core: FAILED **");
    $finish;
  end

  // exact fraction arithmetic, reduced by euclid on 64-bit magnitudes
  function automatic frac_t rational_result(input func_t op, input logic [31:0] an,
                                            input logic [30:0] ad, input logic [31:0] bn,
                                            input logic [30:0] bd);
    frac_t       r;
    logic [63:0] ma, mb, da, db, t1, t2, rn, rd, x, y, rem;
    logic        sa, sb, neg;
    sa = an[31];
    sb = bn[31];
    ma = {32'd0, sa ? ~an + 32'd1 : an};
    mb = {32'd0, sb ? ~bn + 32'd1 : bn};
    da = {33'd0, ad};
    db = {33'd0, bd};
    if (da == 64'd0 || db == 64'd0 || (op == FN_DIV && mb == 64'd0)) begin
      r.num    = an;
      r.den    = ad;
      r.status = STAT_DIV0;
      return r;
    end
    case (op)
      FN_ADD, FN_SUB: begin
        t1 = ma * db;
        t2 = mb * da;
        if (op == FN_SUB) sb = ~sb;
        rd = da * db;
        if (sa == sb) begin
          rn  = t1 + t2;
          neg = sa;
        end else if (t1 >= t2) begin
          rn  = t1 - t2;
          neg = sa;
        end else begin
          rn  = t2 - t1;
          neg = sb;
        end
      end
      FN_MUL: begin
        rn  = ma * mb;
        rd  = da * db;
        neg = sa ^ sb;
      end
      default: begin
        rn  = ma * db;
        rd  = da * mb;
        neg = sa ^ sb;
      end
    endcase
    if (rn == 64'd0) begin
      rd  = 64'd1;
      neg = 1'b0;
    end else begin
      x = rn;
      y = rd;
      while (y != 64'd0) begin
        rem = x % y;
        x   = y;
        y   = rem;
      end
      rn = rn / x;
      rd = rd / x;
    end
    if (rn > RES_LIMIT || rd > RES_LIMIT) begin
      r.num    = 32'sd0;
      r.den    = 31'd1;
      r.status = STAT_OVF;
      return r;
    end
    r.num    = neg ? ~rn[31:0] + 32'd1 : rn[31:0];
    r.den    = rd[30:0];
    r.status = STAT_OK;
    return r;
  endfunction

  function automatic stim_row_t mk_row(input func_t op, input logic [31:0] an,
                                       input logic [30:0] ad, input logic [31:0] bn,
                                       input logic [30:0] bd, input bit known,
                                       input logic [31:0] wn, input logic [30:0] wd,
                                       input status_t ws);
    stim_row_t row;
    row.op          = op;
    row.an          = an;
    row.ad          = ad;
    row.bn          = bn;
    row.bd          = bd;
    row.known       = known;
    row.want.num    = wn;
    row.want.den    = wd;
    row.want.status = ws;
    return row;
  endfunction

  function automatic logic [31:0] signed_upto(input int unsigned mag);
    logic [31:0] v;
    v = $urandom_range(0, mag);
    return ($urandom_range(0, 1) == 1) ? -v : v;
  endfunction

  function automatic logic [31:0] edge_num();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h8000_0001;
      3:       return 32'h0000_0000;
      4:       return 32'h0000_0001;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic [30:0] edge_den();
    case ($urandom_range(0, 2))
      0:       return 31'd1;
      1:       return 31'h7fff_ffff;
      default: return 31'($urandom_range(1, 32'h7fff_ffff));
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < 10) $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  // one word through the handshake; expectation queued once the core is no longer busy
  task automatic send_word(input func_t op, input logic [31:0] an, input logic [30:0] ad,
                           input logic [31:0] bn, input logic [30:0] bd,
                           input bit known, input frac_t want);
    frac_t       exp_res;
    int unsigned gap;
    exp_res = known ? want : rational_result(op, an, ad, bn, bd);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 5);
      start <= 1'b0;
      // sometimes let the core go idle first so the gap lands after busy drops
      if ($urandom_range(0, 1) == 1) begin
        while (busy) @(posedge clk);
      end
      repeat (gap) @(posedge clk);
    end
    in_func  <= op;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    expected_fractions.push_back(exp_res);
  endtask

  task automatic send_random();
    func_t       op;
    logic [31:0] an, bn;
    logic [30:0] ad, bd;
    int unsigned pick, k;
    pick = $urandom_range(0, 99);
    op   = func_t'($urandom_range(0, 3));
    if (pick < 40) begin
      an = signed_upto(1000);
      ad = 31'($urandom_range(1, 1000));
      bn = signed_upto(1000);
      bd = 31'($urandom_range(1, 1000));
    end else if (pick < 60) begin
      an = signed_upto(65535);
      ad = 31'($urandom_range(1, 65535));
      bn = signed_upto(65535);
      bd = 31'($urandom_range(1, 65535));
    end else if (pick < 70) begin
      // shared factors give the reduction real work
      k  = $urandom_range(1, 5000);
      an = signed_upto(300) * k;
      ad = 31'(k * $urandom_range(1, 300));
      k  = $urandom_range(1, 5000);
      bn = signed_upto(300) * k;
      bd = 31'(k * $urandom_range(1, 300));
    end else if (pick < 85) begin
      an = $urandom;
      ad = 31'($urandom);
      bn = $urandom;
      bd = 31'($urandom);
    end else if (pick < 90) begin
      an = edge_num();
      ad = edge_den();
      bn = edge_num();
      bd = edge_den();
    end else if (pick < 95) begin
      op = FN_DIV;
      an = $urandom;
      ad = 31'($urandom_range(1, 32'h7fff_ffff));
      bn = 32'd0;
      bd = 31'($urandom_range(1, 32'h7fff_ffff));
    end else begin
      an = $urandom;
      ad = 31'($urandom);
      bn = $urandom;
      bd = 31'($urandom);
      if ($urandom_range(0, 1) == 1) ad = 31'd0;
      else bd = 31'd0;
    end
    send_word(op, an, ad, bn, bd, 1'b0, '0);
  endtask

  // result checker: the strobe cannot be held off, so every strobed word counts
  always @(posedge clk) begin
    frac_t want;
    if (rst_n && out_valid) begin
      if (expected_fractions.size() == 0) begin
        report_mismatch($sformatf("unexpected word %0d/%0d status %0d",
                                  out_res_num, out_res_den, out_status));
      end else begin
        want = expected_fractions.pop_front();
        if (out_res_num !== want.num || out_res_den !== want.den ||
            out_status !== want.status) begin
          report_mismatch($sformatf("expected %0d/%0d status %0d, got %0d/%0d status %0d",
                                    want.num, want.den, want.status,
                                    out_res_num, out_res_den, out_status));
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    mismatch_count = 0;
    idle_on  = 1'b1;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_func  = FN_ADD;
    in_a_num = '0;
    in_a_den = '0;
    in_b_num = '0;
    in_b_den = '0;

    directed_rows.push_back(mk_row(FN_ADD, 1, 2, 1, 3, 1, 5, 6, STAT_OK));
    directed_rows.push_back(mk_row(FN_SUB, 1, 2, 1, 3, 0, 0, 0, STAT_OK));
    directed_rows.push_back(mk_row(FN_MUL, 2, 3, 3, 4, 0, 0, 0, STAT_OK));
    directed_rows.push_back(mk_row(FN_DIV, 1, 2, 1, 4, 0, 0, 0, STAT_OK));
    directed_rows.push_back(mk_row(FN_DIV, 7, 5, 0, 3, 1, 7, 5, STAT_DIV0));
    directed_rows.push_back(mk_row(FN_DIV, 6, 4, 0, 1, 1, 6, 4, STAT_DIV0));
    directed_rows.push_back(mk_row(FN_ADD, 3, 0, 1, 1, 1, 3, 0, STAT_DIV0));
    directed_rows.push_back(mk_row(FN_MUL, -5, 2, 1, 0, 1, -5, 2, STAT_DIV0));
    directed_rows.push_back(mk_row(FN_SUB, 1, 2, 1, 2, 1, 0, 1, STAT_OK));
    directed_rows.push_back(mk_row(FN_MUL, 0, 7, 5, 3, 1, 0, 1, STAT_OK));
    directed_rows.push_back(mk_row(FN_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1,
                                   1, 0, 1, STAT_OVF));
    directed_rows.push_back(mk_row(FN_MUL, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1,
                                   1, 0, 1, STAT_OVF));
    directed_rows.push_back(mk_row(FN_MUL, 1, 31'h7fff_ffff, 1, 31'h7fff_ffff,
                                   1, 0, 1, STAT_OVF));
    directed_rows.push_back(mk_row(FN_MUL, 32'h8000_0000, 2, 1, 1,
                                   1, -1073741824, 1, STAT_OK));
    directed_rows.push_back(mk_row(FN_ADD, 32'h8000_0000, 1, 0, 1, 1, 0, 1, STAT_OVF));
    directed_rows.push_back(mk_row(FN_MUL, -3, 4, -4, 3, 0, 0, 0, STAT_OK));
    directed_rows.push_back(mk_row(FN_DIV, -1, 3, 2, 5, 0, 0, 0, STAT_OK));
    directed_rows.push_back(mk_row(FN_ADD, 32'h7fff_ffff, 31'h7fff_ffff, 0, 1,
                                   0, 0, 0, STAT_OK));
    directed_rows.push_back(mk_row(FN_DIV, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1,
                                   0, 0, 0, STAT_OK));
    directed_rows.push_back(mk_row(FN_DIV, 0, 5, 3, 7, 1, 0, 1, STAT_OK));
    directed_rows.push_back(mk_row(FN_ADD, 1, 31'h7fff_ffff, 1, 31'h7fff_ffff,
                                   0, 0, 0, STAT_OK));
    directed_rows.push_back(mk_row(FN_SUB, 1, 2, -1, 2, 0, 0, 0, STAT_OK));
    directed_rows.push_back(mk_row(FN_SUB, 32'h7fff_ffff, 1, -1, 1, 0, 0, 0, STAT_OK));
    directed_rows.push_back(mk_row(FN_MUL, 32'h8000_0001, 1, 1, 1,
                                   1, 32'h8000_0001, 1, STAT_OK));
    directed_rows.push_back(mk_row(FN_DIV, 1, 1, -2, 1, 0, 0, 0, STAT_OK));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_word(row.op, row.an, row.ad, row.bn, row.bd, row.known, row.want);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM - CALM_TAIL) idle_on = 1'b0;
      send_random();
    end
    start <= 1'b0;

    while (expected_fractions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("** rational_arith_unit_core: PASSED **");
    end else begin
      $display("** rational_arith_unit_core: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/rau_pkg.sv
rtl/rational_arith_unit_core.sv
tb/tb.sv
